// ----- rtl/mmwo_pkg.sv -----
package mmwo_pkg;

    // bank geometry
    localparam int TABLE_SIZE   = 1024;
    localparam int MIP_LEVELS   = 10;
    localparam int MORPH_POINTS = 9;

    // port field widths
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int FREQ_W   = 32;
    localparam int MORPH_W  = 17;
    localparam int FRAME_W  = 4;
    localparam int LEVEL_W  = 4;
    localparam int INDEX_W  = 10;
    localparam int RATE_W   = 24;

    localparam int RATE_RESET = 48000;

    // table addressing and interpolation
    localparam int TIDX_W     = $clog2(TABLE_SIZE);
    localparam int HALF_W     = TIDX_W - 1;
    localparam int FRAC_W     = PHASE_W - TIDX_W;
    localparam int PROD_SHIFT = 16 - TIDX_W;
    localparam int HALF_LOG2  = TIDX_W - 1;
    localparam int CMP_W      = FREQ_W + HALF_LOG2;
    localparam int NYQ_SHIFT  = 7;
    localparam int FREQ_FLOOR = 256;

    // morph decode
    localparam int MFRAC_W  = 16;
    localparam int MSCALE_W = MORPH_W + $clog2(MORPH_POINTS);
    localparam logic [MORPH_W-1:0] MORPH_ONE = MORPH_W'(65536);

    // four banks: frame parity by index parity
    localparam int BANKS      = 4;
    localparam int BANK_ROWS  = ((MORPH_POINTS + 1) / 2) * MIP_LEVELS;
    localparam int ROW_W      = $clog2(BANK_ROWS);
    localparam int BANK_DEPTH = BANK_ROWS * (TABLE_SIZE / 2);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // datapath widths
    localparam int DS_W  = SAMPLE_W + 1;
    localparam int PROD_W = DS_W + FRAC_W + 1;
    localparam int V_W   = PROD_W - PROD_SHIFT + 1;
    localparam int DV_W  = V_W + 1;
    localparam int BL_W  = DV_W + MFRAC_W + 1;
    localparam int T_W   = BL_W + 1;
    localparam int RES_W = T_W - 32;
    localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

    // queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_DEPTH   = 8;
    localparam int RPTR_W      = $clog2(RES_DEPTH);
    localparam int RCNT_W      = $clog2(RES_DEPTH + 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    typedef struct packed {
        logic                render;
        logic [FRAME_W-1:0]  frame;
        logic                top;
        logic [LEVEL_W-1:0]  level;
        logic [TIDX_W-1:0]   index;
        logic [FRAC_W-1:0]   frac;
        logic [MFRAC_W-1:0]  mfrac;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [LEVEL_W-1:0]  level;
    } result_t;

    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [FRAME_W-1:0] frame,
        input logic [LEVEL_W-1:0] level,
        input logic [TIDX_W-1:0]  idx
    );
        logic [ROW_W-1:0] row;
        row = ROW_W'(int'(frame >> 1) * MIP_LEVELS + int'(level));
        return BANK_AW'({row, idx[TIDX_W-1:1]});
    endfunction

endpackage

// ----- rtl/morphing_mipmap_wavetable_oscillator.sv -----
// Chan Dir Handshake             Payload
// cfg  in  cfg_write             cfg_data (sample rate, Hz)
// in   in  in_valid, in_stall    operation, phase, frequency, morph, load_frame/level/index/sample
// out  out out_valid, out_stall  sample_out, level_used
//
// One item per cycle each way when not stalled. A render result passes, after its item is
// taken, through table read, interpolation product, frame readings, blend product, result FIFO.
// Four single-read table banks (frame parity by index parity) serve a render's four reads.
// Reset sets the sample rate to 48000 and empties the queues; the table is not cleared.
// in_stall rises when the 4-entry command queue is full; renders wait there until the
// 8-entry result FIFO has room for every item in flight.
module morphing_mipmap_wavetable_oscillator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mmwo_pkg::RATE_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [mmwo_pkg::PHASE_W-1:0]         phase,
    input  logic [mmwo_pkg::FREQ_W-1:0]          frequency,
    input  logic [mmwo_pkg::MORPH_W-1:0]         morph,
    input  logic [mmwo_pkg::FRAME_W-1:0]         load_frame,
    input  logic [mmwo_pkg::LEVEL_W-1:0]         load_level,
    input  logic [mmwo_pkg::INDEX_W-1:0]         load_index,
    input  logic signed [mmwo_pkg::SAMPLE_W-1:0] load_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mmwo_pkg::SAMPLE_W-1:0] sample_out,
    output logic [mmwo_pkg::LEVEL_W-1:0]         level_used
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    mmwo_pkg::cmd_t q_in;
    mmwo_pkg::cmd_t q_out;

    mmwo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .phase       (phase),
        .frequency   (frequency),
        .morph       (morph),
        .load_frame  (load_frame),
        .load_level  (load_level),
        .load_index  (load_index),
        .load_sample (load_sample),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    mmwo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    mmwo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .level_used (level_used)
    );

endmodule

// ----- rtl/mmwo_ram.sv -----
module mmwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mmwo_front.sv -----
module mmwo_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [mmwo_pkg::RATE_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [mmwo_pkg::PHASE_W-1:0]          phase,
    input  logic [mmwo_pkg::FREQ_W-1:0]           frequency,
    input  logic [mmwo_pkg::MORPH_W-1:0]          morph,
    input  logic [mmwo_pkg::FRAME_W-1:0]          load_frame,
    input  logic [mmwo_pkg::LEVEL_W-1:0]          load_level,
    input  logic [mmwo_pkg::INDEX_W-1:0]          load_index,
    input  logic signed [mmwo_pkg::SAMPLE_W-1:0]  load_sample,
    input  logic                                  q_full,
    output logic                                  q_push,
    output mmwo_pkg::cmd_t                        q_data
);

    logic [mmwo_pkg::RATE_W-1:0]   rate_reg;
    logic [mmwo_pkg::RATE_W-1:0]   rate_next;
    logic [mmwo_pkg::FREQ_W-1:0]   freq_floor;
    logic [mmwo_pkg::CMP_W-1:0]    nyq;
    logic [mmwo_pkg::MIP_LEVELS-1:0] fits;
    logic [mmwo_pkg::LEVEL_W-1:0]  level;
    logic [mmwo_pkg::MORPH_W-1:0]  morph_clamp;
    logic [mmwo_pkg::MSCALE_W-1:0] mscaled;
    logic [mmwo_pkg::FRAME_W-1:0]  frame_lo;
    logic                          top;
    logic                          is_render;
    logic                          load_ok;

    always_comb
    begin
        rate_next = cfg_write ? cfg_data : rate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= mmwo_pkg::RATE_W'(mmwo_pkg::RATE_RESET);
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    // mip level: first level with (limit * f) <= nyquist, limit a power of two
    always_comb
    begin
        freq_floor = (frequency < mmwo_pkg::FREQ_W'(mmwo_pkg::FREQ_FLOOR))
                   ? mmwo_pkg::FREQ_W'(mmwo_pkg::FREQ_FLOOR) : frequency;
        nyq = mmwo_pkg::CMP_W'({rate_reg, {mmwo_pkg::NYQ_SHIFT{1'b0}}});
        for (int m = 0; m < mmwo_pkg::MIP_LEVELS; m++)
        begin
            if (m >= mmwo_pkg::HALF_LOG2)
            begin
                fits[m] = 1'b1;
            end
            else
            begin
                fits[m] = ((mmwo_pkg::CMP_W'(freq_floor) << (mmwo_pkg::HALF_LOG2 - m)) <= nyq);
            end
        end
        level = mmwo_pkg::LEVEL_W'(mmwo_pkg::MIP_LEVELS - 1);
        for (int m = mmwo_pkg::MIP_LEVELS - 1; m >= 0; m--)
        begin
            if (fits[m])
            begin
                level = mmwo_pkg::LEVEL_W'(m);
            end
        end
        if (rate_reg == '0)
        begin
            level = mmwo_pkg::LEVEL_W'(mmwo_pkg::MIP_LEVELS - 1);
        end
    end

    always_comb
    begin
        morph_clamp = (morph > mmwo_pkg::MORPH_ONE) ? mmwo_pkg::MORPH_ONE : morph;
        mscaled     = mmwo_pkg::MSCALE_W'(morph_clamp)
                    * mmwo_pkg::MSCALE_W'(mmwo_pkg::MORPH_POINTS - 1);
        frame_lo    = mmwo_pkg::FRAME_W'(mscaled >> mmwo_pkg::MFRAC_W);
        top         = (frame_lo == mmwo_pkg::FRAME_W'(mmwo_pkg::MORPH_POINTS - 1));
    end

    always_comb
    begin
        is_render = (mmwo_pkg::op_t'(operation) == mmwo_pkg::OP_RENDER);
        load_ok   = (int'(load_frame) < mmwo_pkg::MORPH_POINTS)
                 && (int'(load_level) < mmwo_pkg::MIP_LEVELS)
                 && (int'(load_index) < mmwo_pkg::TABLE_SIZE);

        q_data.render = is_render;
        if (is_render)
        begin
            q_data.frame  = frame_lo;
            q_data.top    = top;
            q_data.level  = level;
            q_data.index  = phase[mmwo_pkg::PHASE_W-1 -: mmwo_pkg::TIDX_W];
            q_data.frac   = phase[mmwo_pkg::FRAC_W-1:0];
            q_data.mfrac  = top ? '0 : mscaled[mmwo_pkg::MFRAC_W-1:0];
            q_data.sample = '0;
        end
        else
        begin
            q_data.frame  = load_frame;
            q_data.top    = 1'b0;
            q_data.level  = load_level;
            q_data.index  = mmwo_pkg::TIDX_W'(load_index);
            q_data.frac   = '0;
            q_data.mfrac  = '0;
            q_data.sample = load_sample;
        end

        // out-of-range loads are dropped here
        in_stall = q_full;
        q_push   = in_valid && !q_full && (is_render || load_ok);
    end

endmodule

// ----- rtl/mmwo_queue.sv -----
module mmwo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mmwo_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output mmwo_pkg::cmd_t pop_data,
    output logic           empty
);

    mmwo_pkg::cmd_t                entries_reg [mmwo_pkg::QUEUE_DEPTH];
    logic [mmwo_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mmwo_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [mmwo_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mmwo_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [mmwo_pkg::QCNT_W-1:0]   count_reg;
    logic [mmwo_pkg::QCNT_W-1:0]   count_next;

    always_comb
    begin
        full        = (count_reg == mmwo_pkg::QCNT_W'(mmwo_pkg::QUEUE_DEPTH));
        empty       = (count_reg == '0);
        pop_data    = entries_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + mmwo_pkg::QCNT_W'(push) - mmwo_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/mmwo_back.sv -----
module mmwo_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  mmwo_pkg::cmd_t                       q_data,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mmwo_pkg::SAMPLE_W-1:0] sample_out,
    output logic [mmwo_pkg::LEVEL_W-1:0]         level_used
);

    // issue
    logic                            credit_ok;
    logic                            issue_render;
    logic                            issue_load;
    logic [mmwo_pkg::FRAME_W-1:0]    hi_frame;
    logic [mmwo_pkg::FRAME_W-1:0]    even_frame;
    logic [mmwo_pkg::FRAME_W-1:0]    odd_frame;
    logic [mmwo_pkg::TIDX_W-1:0]     next_idx;
    logic [mmwo_pkg::TIDX_W-1:0]     even_idx;
    logic [mmwo_pkg::TIDX_W-1:0]     odd_idx;
    logic [mmwo_pkg::BANK_AW-1:0]    waddr;
    logic [mmwo_pkg::BANK_AW-1:0]    raddr [mmwo_pkg::BANKS];
    logic [mmwo_pkg::BANKS-1:0]      bank_we;
    logic [mmwo_pkg::SAMPLE_W-1:0]   rdata [mmwo_pkg::BANKS];

    // stage 1: table data back
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            s1_lp_reg;
    logic                            s1_ip_reg;
    logic                            s1_top_reg;
    logic [mmwo_pkg::FRAC_W-1:0]     s1_frac_reg;
    logic [mmwo_pkg::MFRAC_W-1:0]    s1_mfrac_reg;
    logic [mmwo_pkg::LEVEL_W-1:0]    s1_level_reg;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] a_lo;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] b_lo;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] a_hi;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] b_hi;
    logic signed [mmwo_pkg::DS_W-1:0]     d_lo;
    logic signed [mmwo_pkg::DS_W-1:0]     d_hi;
    logic signed [mmwo_pkg::PROD_W-1:0]   p_lo;
    logic signed [mmwo_pkg::PROD_W-1:0]   p_hi;

    // stage 2: products of the table interpolation
    logic                                 s2_valid_reg;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] s2_a_lo_reg;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] s2_a_hi_reg;
    logic signed [mmwo_pkg::PROD_W-1:0]   s2_p_lo_reg;
    logic signed [mmwo_pkg::PROD_W-1:0]   s2_p_hi_reg;
    logic [mmwo_pkg::MFRAC_W-1:0]         s2_mfrac_reg;
    logic [mmwo_pkg::LEVEL_W-1:0]         s2_level_reg;
    logic signed [mmwo_pkg::PROD_W-1:0]   psh_lo;
    logic signed [mmwo_pkg::PROD_W-1:0]   psh_hi;
    logic signed [mmwo_pkg::V_W-1:0]      v_lo;
    logic signed [mmwo_pkg::V_W-1:0]      v_hi;

    // stage 3: frame readings
    logic                                 s3_valid_reg;
    logic signed [mmwo_pkg::V_W-1:0]      s3_v_lo_reg;
    logic signed [mmwo_pkg::DV_W-1:0]     s3_diff_reg;
    logic [mmwo_pkg::MFRAC_W-1:0]         s3_mfrac_reg;
    logic [mmwo_pkg::LEVEL_W-1:0]         s3_level_reg;
    logic signed [mmwo_pkg::BL_W-1:0]     blend;

    // stage 4: morph blend product
    logic                                 s4_valid_reg;
    logic signed [mmwo_pkg::V_W-1:0]      s4_v_lo_reg;
    logic signed [mmwo_pkg::BL_W-1:0]     s4_blend_reg;
    logic [mmwo_pkg::LEVEL_W-1:0]         s4_level_reg;
    logic signed [mmwo_pkg::T_W-1:0]      total;
    logic signed [mmwo_pkg::RES_W-1:0]    res;
    mmwo_pkg::result_t                    res_item;

    // result FIFO
    mmwo_pkg::result_t                    rf_reg [mmwo_pkg::RES_DEPTH];
    logic [mmwo_pkg::RPTR_W-1:0]          rf_wr_reg;
    logic [mmwo_pkg::RPTR_W-1:0]          rf_wr_next;
    logic [mmwo_pkg::RPTR_W-1:0]          rf_rd_reg;
    logic [mmwo_pkg::RPTR_W-1:0]          rf_rd_next;
    logic [mmwo_pkg::RCNT_W-1:0]          rf_count_reg;
    logic [mmwo_pkg::RCNT_W-1:0]          rf_count_next;
    logic                                 rf_pop;

    // a render issues only if the result FIFO has room for everything in flight
    always_comb
    begin
        credit_ok = (int'(rf_count_reg) + int'(s1_valid_reg) + int'(s2_valid_reg)
                     + int'(s3_valid_reg) + int'(s4_valid_reg)) < mmwo_pkg::RES_DEPTH;
        q_pop        = !q_empty && (!q_data.render || credit_ok);
        issue_render = q_pop && q_data.render;
        issue_load   = q_pop && !q_data.render;
    end

    // lo/hi frames land in opposite frame-parity banks, i0/i1 in opposite index banks
    always_comb
    begin
        hi_frame   = q_data.top ? q_data.frame : q_data.frame + 1'b1;
        even_frame = q_data.frame[0] ? hi_frame : q_data.frame;
        odd_frame  = q_data.frame[0] ? q_data.frame : hi_frame;
        next_idx   = q_data.index + 1'b1;
        even_idx   = q_data.index[0] ? next_idx : q_data.index;
        odd_idx    = q_data.index[0] ? q_data.index : next_idx;
        waddr      = mmwo_pkg::bank_addr(q_data.frame, q_data.level, q_data.index);
    end

    for (genvar b = 0; b < mmwo_pkg::BANKS; b++)
    begin : g_bank
        always_comb
        begin
            raddr[b]   = mmwo_pkg::bank_addr((b >= 2) ? odd_frame : even_frame,
                                             q_data.level,
                                             (b % 2 == 1) ? odd_idx : even_idx);
            bank_we[b] = issue_load && ({q_data.frame[0], q_data.index[0]} == 2'(b));
        end

        mmwo_ram #(
            .WIDTH (mmwo_pkg::SAMPLE_W),
            .DEPTH (mmwo_pkg::BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (q_data.sample),
            .re    (issue_render),
            .raddr (raddr[b]),
            .rdata (rdata[b])
        );
    end

    always_comb
    begin
        s1_valid_next = issue_render;
    end

    always_ff @(posedge clk)
    begin
        s1_lp_reg    <= q_data.frame[0];
        s1_ip_reg    <= q_data.index[0];
        s1_top_reg   <= q_data.top;
        s1_frac_reg  <= q_data.frac;
        s1_mfrac_reg <= q_data.mfrac;
        s1_level_reg <= q_data.level;
    end

    // stage 1: pick the four samples, interpolation products
    always_comb
    begin
        a_lo = $signed(rdata[{s1_lp_reg, s1_ip_reg}]);
        b_lo = $signed(rdata[{s1_lp_reg, ~s1_ip_reg}]);
        // top frame: the hi reading is the lo one (fraction is zero anyway)
        a_hi = s1_top_reg ? a_lo : $signed(rdata[{~s1_lp_reg, s1_ip_reg}]);
        b_hi = s1_top_reg ? b_lo : $signed(rdata[{~s1_lp_reg, ~s1_ip_reg}]);
        d_lo = mmwo_pkg::DS_W'(b_lo) - mmwo_pkg::DS_W'(a_lo);
        d_hi = mmwo_pkg::DS_W'(b_hi) - mmwo_pkg::DS_W'(a_hi);
        p_lo = d_lo * $signed({1'b0, s1_frac_reg});
        p_hi = d_hi * $signed({1'b0, s1_frac_reg});
    end

    always_ff @(posedge clk)
    begin
        s2_a_lo_reg  <= a_lo;
        s2_a_hi_reg  <= a_hi;
        s2_p_lo_reg  <= p_lo;
        s2_p_hi_reg  <= p_hi;
        s2_mfrac_reg <= s1_mfrac_reg;
        s2_level_reg <= s1_level_reg;
    end

    // stage 2: a*2^16 + floor(d*frac/2^16), frac being phase fraction at 32 bits
    always_comb
    begin
        psh_lo = s2_p_lo_reg >>> mmwo_pkg::PROD_SHIFT;
        psh_hi = s2_p_hi_reg >>> mmwo_pkg::PROD_SHIFT;
        v_lo   = (mmwo_pkg::V_W'(s2_a_lo_reg) <<< 16) + mmwo_pkg::V_W'(psh_lo);
        v_hi   = (mmwo_pkg::V_W'(s2_a_hi_reg) <<< 16) + mmwo_pkg::V_W'(psh_hi);
    end

    always_ff @(posedge clk)
    begin
        s3_v_lo_reg  <= v_lo;
        s3_diff_reg  <= mmwo_pkg::DV_W'(v_hi) - mmwo_pkg::DV_W'(v_lo);
        s3_mfrac_reg <= s2_mfrac_reg;
        s3_level_reg <= s2_level_reg;
    end

    always_comb
    begin
        blend = s3_diff_reg * $signed({1'b0, s3_mfrac_reg});
    end

    always_ff @(posedge clk)
    begin
        s4_v_lo_reg  <= s3_v_lo_reg;
        s4_blend_reg <= blend;
        s4_level_reg <= s3_level_reg;
    end

    // stage 4: floor to the sample grid and saturate
    always_comb
    begin
        total = (mmwo_pkg::T_W'(s4_v_lo_reg) <<< 16) + mmwo_pkg::T_W'(s4_blend_reg);
        res   = mmwo_pkg::RES_W'(total >>> 32);
        if (res > mmwo_pkg::SAMPLE_MAX)
        begin
            res_item.sample = mmwo_pkg::SAMPLE_W'(mmwo_pkg::SAMPLE_MAX);
        end
        else if (res < mmwo_pkg::SAMPLE_MIN)
        begin
            res_item.sample = mmwo_pkg::SAMPLE_W'(mmwo_pkg::SAMPLE_MIN);
        end
        else
        begin
            res_item.sample = mmwo_pkg::SAMPLE_W'(res);
        end
        res_item.level = s4_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        out_valid     = (rf_count_reg != '0);
        rf_pop        = out_valid && !out_stall;
        sample_out    = $signed(rf_reg[rf_rd_reg].sample);
        level_used    = rf_reg[rf_rd_reg].level;
        rf_wr_next    = s4_valid_reg ? rf_wr_reg + 1'b1 : rf_wr_reg;
        rf_rd_next    = rf_pop ? rf_rd_reg + 1'b1 : rf_rd_reg;
        rf_count_next = rf_count_reg + mmwo_pkg::RCNT_W'(s4_valid_reg)
                      - mmwo_pkg::RCNT_W'(rf_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_wr_reg    <= '0;
            rf_rd_reg    <= '0;
            rf_count_reg <= '0;
        end
        else
        begin
            rf_wr_reg    <= rf_wr_next;
            rf_rd_reg    <= rf_rd_next;
            rf_count_reg <= rf_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            rf_reg[rf_wr_reg] <= res_item;
        end
    end

endmodule

// ----- tb/morphing_mipmap_wavetable_oscillator_test.sv -----
`timescale 1ns / 1ps

module morphing_mipmap_wavetable_oscillator_test;

    localparam int BANK_ENTRIES   = mmwo_pkg::MORPH_POINTS * mmwo_pkg::MIP_LEVELS
                                  * mmwo_pkg::TABLE_SIZE;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        mmwo_pkg::op_t                        op;
        logic [mmwo_pkg::PHASE_W-1:0]         phase;
        logic [mmwo_pkg::FREQ_W-1:0]          freq;
        logic [mmwo_pkg::MORPH_W-1:0]         morph;
        logic [mmwo_pkg::FRAME_W-1:0]         frame;
        logic [mmwo_pkg::LEVEL_W-1:0]         level;
        logic [mmwo_pkg::INDEX_W-1:0]         index;
        logic signed [mmwo_pkg::SAMPLE_W-1:0] sample;
    } osc_item_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [mmwo_pkg::RATE_W-1:0]          cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 operation = 1'b0;
    logic [mmwo_pkg::PHASE_W-1:0]         phase = '0;
    logic [mmwo_pkg::FREQ_W-1:0]          frequency = '0;
    logic [mmwo_pkg::MORPH_W-1:0]         morph = '0;
    logic [mmwo_pkg::FRAME_W-1:0]         load_frame = '0;
    logic [mmwo_pkg::LEVEL_W-1:0]         load_level = '0;
    logic [mmwo_pkg::INDEX_W-1:0]         load_index = '0;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] load_sample = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [mmwo_pkg::SAMPLE_W-1:0] sample_out;
    logic [mmwo_pkg::LEVEL_W-1:0]         level_used;

    morphing_mipmap_wavetable_oscillator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .phase       (phase),
        .frequency   (frequency),
        .morph       (morph),
        .load_frame  (load_frame),
        .load_level  (load_level),
        .load_index  (load_index),
        .load_sample (load_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .level_used  (level_used)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    osc_item_t                            pending_items[$];
    mmwo_pkg::result_t                    expected_results[$];
    osc_item_t                            current_item;
    mmwo_pkg::result_t                    want;

    // predictor state
    logic signed [mmwo_pkg::SAMPLE_W-1:0] bank_model [BANK_ENTRIES];
    logic [mmwo_pkg::RATE_W-1:0]          rate_setting = mmwo_pkg::RATE_W'(mmwo_pkg::RATE_RESET);

    // generator state: entries that some queued load has written
    bit                         loaded [BANK_ENTRIES];
    int                         stim_count = 0;

    int                         errors = 0;
    int                         gap_left = 0;
    int                         stall_left = 0;
    int                         hold_left = 0;
    int                         idle_cycles = 0;
    bit                         quiet_in = 1'b0;
    bit                         quiet_out = 1'b0;
    bit                         squeeze_req = 1'b0;
    bit                         squeeze_done = 1'b0;

    function automatic int entry_of(int frame, int level, int index);
        return (frame * mmwo_pkg::MIP_LEVELS + level) * mmwo_pkg::TABLE_SIZE + index;
    endfunction

    function automatic logic [mmwo_pkg::LEVEL_W-1:0] mip_for(
        logic [mmwo_pkg::FREQ_W-1:0] freq,
        logic [mmwo_pkg::RATE_W-1:0] rate
    );
        longint unsigned f;
        longint unsigned nyq;
        longint unsigned lim;
        f   = (freq < mmwo_pkg::FREQ_FLOOR) ? 64'(mmwo_pkg::FREQ_FLOOR) : 64'(freq);
        nyq = 64'(rate) * 64'd128;
        if (rate == '0)
            return mmwo_pkg::LEVEL_W'(mmwo_pkg::MIP_LEVELS - 1);
        for (int m = 0; m < mmwo_pkg::MIP_LEVELS; m++)
        begin
            lim = 64'((mmwo_pkg::TABLE_SIZE / 2) >> m);
            if (lim == 0)
                lim = 1;
            if (lim == 1 || lim * f <= nyq)
                return mmwo_pkg::LEVEL_W'(m);
        end
        return mmwo_pkg::LEVEL_W'(mmwo_pkg::MIP_LEVELS - 1);
    endfunction

    function automatic void morph_frames(input logic [mmwo_pkg::MORPH_W-1:0] mo,
                                         output int lo, output int hi,
                                         output longint mfrac);
        longint unsigned mp;
        mp    = (mo > mmwo_pkg::MORPH_ONE) ? 64'(mmwo_pkg::MORPH_ONE) : 64'(mo);
        mp    = mp * 64'(mmwo_pkg::MORPH_POINTS - 1);
        lo    = int'(mp >> 16);
        mfrac = longint'(mp & 64'hFFFF);
        if (lo >= mmwo_pkg::MORPH_POINTS)
            lo = mmwo_pkg::MORPH_POINTS - 1;
        hi = lo + 1;
        if (hi >= mmwo_pkg::MORPH_POINTS)
        begin
            hi    = lo;
            mfrac = 0;
        end
    endfunction

    // one table reading with 16 extra fraction bits
    function automatic longint table_read(int frame, int level,
                                          logic [mmwo_pkg::PHASE_W-1:0] ph);
        int                           i0;
        int                           i1;
        logic [mmwo_pkg::PHASE_W-1:0] fr_bits;
        longint                       a;
        longint                       b;
        longint                       fr;
        i0      = int'(ph >> (mmwo_pkg::PHASE_W - mmwo_pkg::TIDX_W));
        i1      = (i0 + 1) % mmwo_pkg::TABLE_SIZE;
        fr_bits = ph << mmwo_pkg::TIDX_W;
        fr      = longint'(64'(fr_bits));
        a       = bank_model[entry_of(frame, level, i0)];
        b       = bank_model[entry_of(frame, level, i1)];
        return a * 65536 + (((b - a) * fr) >>> 16);
    endfunction

    function automatic mmwo_pkg::result_t render_expect(osc_item_t it);
        mmwo_pkg::result_t r;
        int                lvl;
        int                lo;
        int                hi;
        longint            mfrac;
        longint            vlo;
        longint            vhi;
        longint            total;
        longint            res;
        lvl = int'(mip_for(it.freq, rate_setting));
        morph_frames(it.morph, lo, hi, mfrac);
        vlo   = table_read(lo, lvl, it.phase);
        vhi   = table_read(hi, lvl, it.phase);
        total = vlo * 65536 + (vhi - vlo) * mfrac;
        res   = total >>> 32;
        if (res > mmwo_pkg::SAMPLE_MAX)
            res = mmwo_pkg::SAMPLE_MAX;
        if (res < mmwo_pkg::SAMPLE_MIN)
            res = mmwo_pkg::SAMPLE_MIN;
        r.sample = mmwo_pkg::SAMPLE_W'(res);
        r.level  = mmwo_pkg::LEVEL_W'(lvl);
        return r;
    endfunction

    function automatic void apply_item(osc_item_t it);
        if (it.op == mmwo_pkg::OP_LOAD)
        begin
            if (it.frame < mmwo_pkg::MORPH_POINTS && it.level < mmwo_pkg::MIP_LEVELS)
                bank_model[entry_of(it.frame, it.level, it.index)] = it.sample;
        end
        else
            expected_results.push_back(render_expect(it));
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // fields that the operation does not use carry random bits
    function automatic osc_item_t filler_item(mmwo_pkg::op_t op);
        osc_item_t it;
        it.op     = op;
        it.phase  = $urandom;
        it.freq   = $urandom;
        it.morph  = mmwo_pkg::MORPH_W'($urandom);
        it.frame  = mmwo_pkg::FRAME_W'($urandom);
        it.level  = mmwo_pkg::LEVEL_W'($urandom);
        it.index  = mmwo_pkg::INDEX_W'($urandom);
        it.sample = mmwo_pkg::SAMPLE_W'($urandom);
        return it;
    endfunction

    task automatic queue_load(int frame, int level, int index,
                              logic [mmwo_pkg::SAMPLE_W-1:0] value);
        osc_item_t it;
        it        = filler_item(mmwo_pkg::OP_LOAD);
        it.frame  = mmwo_pkg::FRAME_W'(frame);
        it.level  = mmwo_pkg::LEVEL_W'(level);
        it.index  = mmwo_pkg::INDEX_W'(index);
        it.sample = value;
        pending_items.push_back(it);
        if (frame < mmwo_pkg::MORPH_POINTS && level < mmwo_pkg::MIP_LEVELS)
        begin
            loaded[entry_of(frame, level, index)] = 1'b1;
            stim_count++;
        end
    endtask

    // load a tap if it was never written, and now and then rewrite it anyway
    task automatic prime_tap(int frame, int level, int index);
        if (!loaded[entry_of(frame, level, index)] || $urandom_range(0, 7) == 0)
            queue_load(frame, level, index, mmwo_pkg::SAMPLE_W'($urandom));
    endtask

    task automatic queue_render(logic [mmwo_pkg::PHASE_W-1:0] ph,
                                logic [mmwo_pkg::FREQ_W-1:0] fq,
                                logic [mmwo_pkg::MORPH_W-1:0] mo);
        osc_item_t it;
        int        lvl;
        int        lo;
        int        hi;
        int        i0;
        int        i1;
        longint    mfrac;
        lvl = int'(mip_for(fq, rate_setting));
        morph_frames(mo, lo, hi, mfrac);
        i0 = int'(ph >> (mmwo_pkg::PHASE_W - mmwo_pkg::TIDX_W));
        i1 = (i0 + 1) % mmwo_pkg::TABLE_SIZE;
        prime_tap(lo, lvl, i0);
        prime_tap(lo, lvl, i1);
        prime_tap(hi, lvl, i0);
        prime_tap(hi, lvl, i1);
        it       = filler_item(mmwo_pkg::OP_RENDER);
        it.phase = ph;
        it.freq  = fq;
        it.morph = mo;
        pending_items.push_back(it);
        stim_count++;
    endtask

    task automatic queue_random_render();
        logic [mmwo_pkg::PHASE_W-1:0] ph;
        logic [mmwo_pkg::FREQ_W-1:0]  fq;
        logic [mmwo_pkg::MORPH_W-1:0] mo;
        int                           r;
        ph = $urandom;
        // bias some phases to the table ends to exercise the wrap
        if ($urandom_range(0, 3) == 0)
            ph[mmwo_pkg::PHASE_W-1 -: mmwo_pkg::TIDX_W] = $urandom_range(0, 1)
                ? mmwo_pkg::TIDX_W'($urandom_range(0, 3))
                : mmwo_pkg::TIDX_W'(mmwo_pkg::TABLE_SIZE - 1 - $urandom_range(0, 3));
        // log-spread frequency so every mip level shows up
        fq = $urandom >> $urandom_range(0, 31);
        r  = $urandom_range(0, 9);
        if (r < 6)
            mo = mmwo_pkg::MORPH_W'($urandom_range(0, 65536));
        else if (r < 8)
            mo = mmwo_pkg::MORPH_W'((65536 / (mmwo_pkg::MORPH_POINTS - 1))
                                    * $urandom_range(0, mmwo_pkg::MORPH_POINTS - 1));
        else
            mo = mmwo_pkg::MORPH_W'($urandom);
        queue_render(ph, fq, mo);
    endtask

    task automatic random_batch(int n);
        int goal;
        goal = stim_count + n;
        while (stim_count < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_load($urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, mmwo_pkg::TABLE_SIZE - 1),
                           mmwo_pkg::SAMPLE_W'($urandom));
            else
                queue_random_render();
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        // loads still in the pipe produce nothing, give them time to land
        repeat (10) @(negedge clk);
    endtask

    task automatic write_rate(logic [mmwo_pkg::RATE_W-1:0] r);
        @(posedge clk);
        cfg_write    <= 1'b1;
        cfg_data     <= r;
        rate_setting = r;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_item(current_item);
            if ($urandom_range(0, 99) == 0)
                quiet_in = !quiet_in;
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    current_item = pending_items.pop_front();
                    operation    <= current_item.op;
                    phase        <= current_item.phase;
                    frequency    <= current_item.freq;
                    morph        <= current_item.morph;
                    load_frame   <= current_item.frame;
                    load_level   <= current_item.level;
                    load_index   <= current_item.index;
                    load_sample  <= current_item.sample;
                    in_valid     <= 1'b1;
                    gap_left = (squeeze_req || quiet_in) ? 0 : idle_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with none expected: sample_out=%0d level_used=%0d",
                           sample_out, level_used);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.sample), sample_out);
                        errors++;
                    end
                    if (level_used !== want.level)
                    begin
                        $error("level_used: expected %0d, actual %0d", want.level, level_used);
                        errors++;
                    end
                end
            end
            if (squeeze_req && !squeeze_done)
            begin
                hold_left    = HOLD_CYCLES;
                squeeze_done = 1'b1;
            end
            if ($urandom_range(0, 99) == 0)
                quiet_out = !quiet_out;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_out && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_len();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [mmwo_pkg::RATE_W-1:0] rates [7];
        rates = '{24'd0, 24'hFFFFFF, 24'd1, 24'd44100, 24'd96000,
                  mmwo_pkg::RATE_W'($urandom_range(2, 24'hFFFFFE)), 24'd8000};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, at the reset sample rate
        queue_load(0, 0, 0, 16'h7FFF);
        queue_load(0, 0, 1, 16'h8000);
        queue_load(0, 0, mmwo_pkg::TABLE_SIZE - 1, 16'h8000);
        queue_load(1, 0, 0, 16'h8000);
        queue_load(1, 0, 1, 16'h7FFF);
        queue_render(32'h0000_0000, 32'd0, 17'd0);          // below 1 Hz, exact table point
        queue_render(32'h003F_FFFF, 32'd255, 17'd8191);     // full swing, both fractions high
        queue_render(32'hFFFF_FFFF, 32'd12000, 17'd0);      // wrap to entry 0, at the level edge
        queue_render(32'h8000_0000, 32'd12001, 17'd4096);   // just past the edge
        // out of range loads must not touch the bank
        queue_load(15, 0, 0, 16'h1234);
        queue_load(9, 0, 0, 16'h4321);
        queue_load(0, 10, 0, 16'h5A5A);
        queue_load(0, 15, mmwo_pkg::TABLE_SIZE - 1, 16'hA5A5);
        queue_render(32'h0000_0000, 32'd0, 17'd0);
        queue_render($urandom, 32'hFFFF_FFFF, 17'd65536);   // top frame, last level
        queue_render($urandom, 32'd1000000, 17'h1FFFF);     // morph clamps
        queue_render($urandom, 32'd5000, 17'd8192);         // exactly on a frame
        queue_render($urandom, 32'd5000, 17'd65535);        // just under the top frame
        drain();

        foreach (rates[i])
        begin
            write_rate(rates[i]);
            random_batch(95);
            drain();
        end

        // receiver holds off while the sender keeps pushing
        write_rate(mmwo_pkg::RATE_W'(mmwo_pkg::RATE_RESET));
        squeeze_req = 1'b1;
        random_batch(60);
        drain();
        squeeze_req = 1'b0;

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
